FILE: sv/ictt_pkg.sv
// Shared types and constants for the idle connection timeout tracker.
package ictt_pkg;

    localparam int ID_W    = 5;
    localparam int LIMIT_W = 40;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd10000000;

    typedef enum logic [1:0] {
        ACT_CONNECT    = 2'd0,
        ACT_DISCONNECT = 2'd1,
        ACT_MESSAGE    = 2'd2,
        ACT_TICK       = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNLINK,
        ST_APPEND,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // age check verdict for one list entry
    typedef struct packed {
        logic jump;
        logic expired;
    } age_t;

    // one close result handed to the output register
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic            last;
    } push_t;

endpackage

FILE: sv/ictt_age.sv
// Shared age unit: time jump detect and idle limit compare for one stamp.
module ictt_age #(
    parameter int TIME_BITS = 48
) (
    input  logic [TIME_BITS-1:0]         time_now,
    input  logic [TIME_BITS-1:0]         stamp,
    input  logic [ictt_pkg::LIMIT_W-1:0] idle_limit,
    output ictt_pkg::age_t               verdict
);

    localparam int CMP_W = (TIME_BITS > ictt_pkg::LIMIT_W) ? TIME_BITS : ictt_pkg::LIMIT_W;

    logic [TIME_BITS-1:0] age;

    assign age = time_now - stamp;

    always_comb begin
        verdict.jump    = time_now < stamp;
        verdict.expired = CMP_W'(age) > CMP_W'(idle_limit);
    end

endmodule

FILE: sv/ictt_ctrl.sv
// Sequencer, link and stamp memories, and slot flags of the tracker.
module ictt_ctrl #(
    parameter int MAX_CONNS = 32,
    parameter int TIME_BITS = 48
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_action,
    input  logic [ictt_pkg::ID_W-1:0]    in_conn_id,
    input  logic [TIME_BITS-1:0]         in_time_now,
    input  logic [ictt_pkg::LIMIT_W-1:0] idle_limit,
    input  logic                         out_free,
    output ictt_pkg::push_t              push
);

    localparam int IDX_W = $clog2(MAX_CONNS);

    ictt_pkg::state_t  state_reg, state_next;
    ictt_pkg::action_t act_reg, act_next;
    ictt_pkg::action_t in_act;
    ictt_pkg::age_t    verdict;

    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic                 empty_reg, empty_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_id_reg, pend_id_next;
    logic [MAX_CONNS-1:0] used_reg, used_next;
    logic [MAX_CONNS-1:0] closing_reg, closing_next;

    logic [TIME_BITS-1:0] stamp_mem [MAX_CONNS];
    logic [IDX_W-1:0]     next_mem  [MAX_CONNS];
    logic [IDX_W-1:0]     prev_mem  [MAX_CONNS];
    logic [TIME_BITS-1:0] stamp_rd;
    logic [IDX_W-1:0]     next_rd;
    logic [IDX_W-1:0]     prev_rd;

    logic                 stamp_we;
    logic                 next_we;
    logic [IDX_W-1:0]     next_wa, next_wd;
    logic                 prev_we;
    logic [IDX_W-1:0]     prev_wa, prev_wd;

    logic                 accept;
    logic                 id_ok;
    logic [IDX_W-1:0]     in_id;
    logic                 cur_is_tail;
    logic                 new_close;
    logic                 walk_stall;
    logic                 walk_adv;
    logic                 walk_end;

    assign in_act      = ictt_pkg::action_t'(in_action);
    assign in_ready    = state_reg == ictt_pkg::ST_IDLE;
    assign accept      = in_valid && in_ready;
    assign id_ok       = 32'(in_conn_id) < MAX_CONNS;
    assign in_id       = IDX_W'(in_conn_id);
    assign cur_is_tail = cur_reg == tail_reg;

    ictt_age #(
        .TIME_BITS (TIME_BITS)
    ) u_age (
        .time_now   (now_reg),
        .stamp      (stamp_rd),
        .idle_limit (idle_limit),
        .verdict    (verdict)
    );

    // walk step decisions on the entry whose data was just read
    assign new_close  = !verdict.jump && verdict.expired && !closing_reg[cur_reg];
    assign walk_stall = new_close && pend_valid_reg && !out_free;
    assign walk_adv   = verdict.jump || (verdict.expired && !walk_stall);
    assign walk_end   = !walk_stall && (!walk_adv || cur_is_tail);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ictt_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (in_act == ictt_pkg::ACT_TICK) begin
                        state_next = empty_reg ? ictt_pkg::ST_IDLE : ictt_pkg::ST_WALK;
                    end else if (!id_ok) begin
                        state_next = ictt_pkg::ST_IDLE;
                    end else if (in_act == ictt_pkg::ACT_CONNECT) begin
                        state_next = used_reg[in_id] ? ictt_pkg::ST_IDLE
                                                     : ictt_pkg::ST_APPEND;
                    end else if (!used_reg[in_id]) begin
                        state_next = ictt_pkg::ST_IDLE;
                    end else if (in_act == ictt_pkg::ACT_MESSAGE && in_id == tail_reg) begin
                        state_next = ictt_pkg::ST_APPEND;
                    end else begin
                        state_next = ictt_pkg::ST_UNLINK;
                    end
                end
            end
            ictt_pkg::ST_UNLINK: begin
                state_next = (act_reg == ictt_pkg::ACT_MESSAGE) ? ictt_pkg::ST_APPEND
                                                                : ictt_pkg::ST_IDLE;
            end
            ictt_pkg::ST_APPEND: begin
                state_next = ictt_pkg::ST_IDLE;
            end
            ictt_pkg::ST_WALK: begin
                if (walk_end) begin
                    state_next = (pend_valid_reg || new_close) ? ictt_pkg::ST_FLUSH
                                                               : ictt_pkg::ST_IDLE;
                end
            end
            ictt_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = ictt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ictt_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory write controls
    always_comb begin
        act_next        = act_reg;
        now_next        = now_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        used_next       = used_reg;
        closing_next    = closing_reg;
        stamp_we        = 1'b0;
        next_we         = 1'b0;
        next_wa         = tail_reg;
        next_wd         = cur_reg;
        prev_we         = 1'b0;
        prev_wa         = cur_reg;
        prev_wd         = tail_reg;
        push.valid      = 1'b0;
        push.id         = ictt_pkg::ID_W'(pend_id_reg);
        push.last       = 1'b0;
        unique case (state_reg)
            ictt_pkg::ST_IDLE: begin
                if (accept) begin
                    act_next        = in_act;
                    now_next        = in_time_now;
                    pend_valid_next = 1'b0;
                    cur_next        = (in_act == ictt_pkg::ACT_TICK) ? head_reg : in_id;
                end
            end
            ictt_pkg::ST_UNLINK: begin
                if (head_reg == cur_reg && cur_is_tail) begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end else begin
                    if (head_reg == cur_reg) begin
                        head_next = next_rd;
                    end else begin
                        next_we = 1'b1;
                        next_wa = prev_rd;
                        next_wd = next_rd;
                    end
                    if (cur_is_tail) begin
                        tail_next = prev_rd;
                    end else begin
                        prev_we = 1'b1;
                        prev_wa = next_rd;
                        prev_wd = prev_rd;
                    end
                end
                if (act_reg == ictt_pkg::ACT_DISCONNECT) begin
                    used_next[cur_reg]    = 1'b0;
                    closing_next[cur_reg] = 1'b0;
                end
            end
            ictt_pkg::ST_APPEND: begin
                stamp_we = 1'b1;
                if (empty_reg) begin
                    head_next  = cur_reg;
                    tail_next  = cur_reg;
                    empty_next = 1'b0;
                end else if (!cur_is_tail) begin
                    next_we   = 1'b1;
                    prev_we   = 1'b1;
                    tail_next = cur_reg;
                end
                if (act_reg == ictt_pkg::ACT_CONNECT) begin
                    used_next[cur_reg]    = 1'b1;
                    closing_next[cur_reg] = 1'b0;
                end
            end
            ictt_pkg::ST_WALK: begin
                // stamp in the future: pull it back to now
                stamp_we = verdict.jump;
                if (new_close && !walk_stall) begin
                    push.valid            = pend_valid_reg;
                    pend_valid_next       = 1'b1;
                    pend_id_next          = cur_reg;
                    closing_next[cur_reg] = 1'b1;
                end
                if (walk_adv && !cur_is_tail) begin
                    cur_next = next_rd;
                end
            end
            ictt_pkg::ST_FLUSH: begin
                if (out_free) begin
                    push.valid      = 1'b1;
                    push.last       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ictt_pkg::ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            empty_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
            used_reg       <= '0;
            closing_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            empty_reg      <= empty_next;
            pend_valid_reg <= pend_valid_next;
            used_reg       <= used_next;
            closing_reg    <= closing_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg     <= act_next;
        now_reg     <= now_next;
        cur_reg     <= cur_next;
        pend_id_reg <= pend_id_next;
    end

    // read address follows cur, so data for the next entry lands as it is examined
    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[cur_reg] <= now_reg;
        end
        stamp_rd <= stamp_mem[cur_next];
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd <= next_mem[cur_next];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_rd <= prev_mem[cur_next];
    end

endmodule

FILE: sv/idle_connection_timeout_tracker_unit.sv
// Top level of the idle connection timeout tracker: config register and result register.
//
// Input channel (s_*): one event per transfer: connect, disconnect, message or tick,
// with a slot id and the current time in microseconds. s_ready is high only while
// the sequencer is idle; one event is worked on at a time.
// Config channel (cfg_*): writes the idle limit; always ready, write only while idle.
// Result channel (m_*): one close transfer per slot newly found idle during a tick, head
// to tail, with m_last_close set on the final one of that tick.
// Event paths: connect runs append, disconnect runs unlink, message runs unlink then
// append (only append when already at tail); ignored events go back to idle.
// A tick walks from the head, one entry at a time, then flushes a pending close; the
// walk shares a single age compare unit and one read port per link/stamp memory.
// A close result is held in the output register; when the receiver stalls with a
// second result ready, the walk holds on the current entry until the register frees.
// Reset (aresetn low, synchronous) empties the list, clears all slot flags and sets
// the idle limit to 10 s; stamp and link memories need no clearing.
module idle_connection_timeout_tracker_unit #(
    parameter int MAX_CONNS = 32,
    parameter int TIME_BITS = 48
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [ictt_pkg::ID_W-1:0]    s_conn_id,
    input  logic [TIME_BITS-1:0]         s_time_now,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ictt_pkg::LIMIT_W-1:0] cfg_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ictt_pkg::ID_W-1:0]    m_close_id,
    output logic                         m_last_close
);

    logic [ictt_pkg::LIMIT_W-1:0] limit_reg;
    logic                         m_valid_reg;
    logic [ictt_pkg::ID_W-1:0]    close_id_reg;
    logic                         last_reg;
    logic                         out_free;
    ictt_pkg::push_t              push;

    assign cfg_ready    = 1'b1;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_close_id   = close_id_reg;
    assign m_last_close = last_reg;

    ictt_ctrl #(
        .MAX_CONNS (MAX_CONNS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_action   (s_action),
        .in_conn_id  (s_conn_id),
        .in_time_now (s_time_now),
        .idle_limit  (limit_reg),
        .out_free    (out_free),
        .push        (push)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= ictt_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (push.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            close_id_reg <= push.id;
            last_reg     <= push.last;
        end
    end

endmodule

FILE: verif/tb_idle_connection_timeout_tracker_unit.sv
// Self-checking testbench for the idle connection timeout tracker: list, expiry walk, limit.
module tb_idle_connection_timeout_tracker_unit;

    localparam int          ID_W          = ictt_pkg::ID_W;
    localparam int          LIMIT_W       = ictt_pkg::LIMIT_W;
    localparam int          SLOTS         = 32;
    localparam int          SETTLE_CYCLES = 48;    // full-list tick walk plus margin
    localparam int          LONG_HOLD     = 400;
    localparam bit [47:0]   LIM0          = 48'd10_000_000;

    typedef struct {
        bit [ID_W-1:0] id;
        bit            last_close;
    } close_t;

    // Shadow of the slot list; predicts the close transfers of every tick.
    class close_scoreboard;
        bit               used [SLOTS];
        bit               closing [SLOTS];
        bit [47:0]        stamp [SLOTS];
        bit [ID_W-1:0]    nxt [SLOTS];
        bit [ID_W-1:0]    prv [SLOTS];
        bit [ID_W-1:0]    head;
        bit [ID_W-1:0]    tail;
        bit               empty;
        bit [LIMIT_W-1:0] limit;
        int               errors;
        close_t           pending_closes[$];

        function new();
            empty = 1'b1;
            limit = ictt_pkg::LIMIT_RESET;
        endfunction

        function void unlink(bit [ID_W-1:0] id);
            if (head == id && tail == id) begin
                empty = 1'b1;
                head  = '0;
                tail  = '0;
                return;
            end
            if (head == id) head = nxt[id];
            else            nxt[prv[id]] = nxt[id];
            if (tail == id) tail = prv[id];
            else            prv[nxt[id]] = prv[id];
        endfunction

        function void append(bit [ID_W-1:0] id);
            if (empty) begin
                head  = id;
                tail  = id;
                empty = 1'b0;
            end else begin
                nxt[tail] = id;
                prv[id]   = tail;
                tail      = id;
            end
            nxt[id] = id;
        endfunction

        function void note_event(ictt_pkg::action_t act, bit [ID_W-1:0] id, bit [47:0] now);
            bit [ID_W-1:0] cur;
            bit [47:0]     age;
            int            first;
            close_t        item;
            first = pending_closes.size();
            case (act)
                ictt_pkg::ACT_TICK: begin
                    if (!empty) begin
                        cur = head;
                        for (int n = 0; n < SLOTS; n++) begin
                            age = now - stamp[cur];
                            if (now < stamp[cur]) begin
                                stamp[cur] = now;          // clock went backwards
                            end else if (age > {8'd0, limit}) begin
                                if (!closing[cur]) begin
                                    closing[cur]    = 1'b1;
                                    item.id         = cur;
                                    item.last_close = 1'b0;
                                    pending_closes  = {pending_closes, item};
                                end
                            end else begin
                                break;
                            end
                            if (cur == tail) break;
                            cur = nxt[cur];
                        end
                        if (pending_closes.size() > first)
                            pending_closes[pending_closes.size() - 1].last_close = 1'b1;
                    end
                end
                ictt_pkg::ACT_CONNECT: begin
                    if (!used[id]) begin
                        used[id]    = 1'b1;
                        closing[id] = 1'b0;
                        stamp[id]   = now;
                        append(id);
                    end
                end
                ictt_pkg::ACT_DISCONNECT: begin
                    if (used[id]) begin
                        unlink(id);
                        used[id]    = 1'b0;
                        closing[id] = 1'b0;
                    end
                end
                default: begin
                    if (used[id]) begin
                        stamp[id] = now;
                        unlink(id);
                        append(id);
                    end
                end
            endcase
        endfunction

        function void check_close(logic [ID_W-1:0] id, logic last_close);
            close_t exp;
            if (pending_closes.size() == 0) begin
                $error("unexpected close transfer: close_id %0d last_close %0b", id, last_close);
                errors++;
                return;
            end
            exp = pending_closes.pop_front();
            if (id !== exp.id) begin
                $error("close_id mismatch: expected %0d, actual %0d", exp.id, id);
                errors++;
            end
            if (last_close !== exp.last_close) begin
                $error("last_close mismatch: expected %0b, actual %0b",
                       exp.last_close, last_close);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_action;
    logic [ID_W-1:0]     s_conn_id;
    logic [47:0]         s_time_now;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data;
    logic                m_valid;
    logic                m_ready;
    logic [ID_W-1:0]     m_close_id;
    logic                m_last_close;

    close_scoreboard     board;
    bit [47:0]           now_us;
    bit                  gaps_on;
    int                  burst_left;
    bit                  hold_request;

    idle_connection_timeout_tracker_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_conn_id    (s_conn_id),
        .s_time_now   (s_time_now),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_close_id   (m_close_id),
        .m_last_close (m_last_close)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // One event transfer; valid stays up into the next call unless a gap is taken.
    task automatic offer(input ictt_pkg::action_t act, input bit [ID_W-1:0] id,
                         input bit [47:0] t);
        s_valid    <= 1'b1;
        s_action   <= act;
        s_conn_id  <= id;
        s_time_now <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_event(act, id, t);
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                s_valid <= 1'b0;
                if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 40)) @(posedge aclk);
                else                           repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop sending until every predicted close has arrived and the walk has settled.
    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (board.pending_closes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input bit [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.limit = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_slot(input bit want_used);
        int cands[$];
        for (int i = 0; i < SLOTS; i++)
            if (board.used[i] == want_used) cands = {cands, i};
        if (cands.size() == 0) return -1;
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // Mostly short steps, some near or past the limit, a few backwards jumps.
    function automatic bit [47:0] advance_time(input bit [47:0] t, input bit [LIMIT_W-1:0] lim);
        int unsigned pick;
        bit [63:0]   span;
        pick = $urandom_range(0, 99);
        if (pick < 45)      span = {$urandom, $urandom} % ({24'd0, lim} / 4 + 1);
        else if (pick < 65) span = {24'd0, lim} + $urandom_range(0, 2);
        else if (pick < 80) span = {24'd0, lim} + {32'd0, $urandom};
        else if (pick < 92) span = '0;
        else return t - 48'({$urandom, $urandom} % ({24'd0, lim} + 2));
        return t + span[47:0];
    endfunction

    task automatic random_events(input int count);
        int                done;
        int                pick;
        int                slot;
        ictt_pkg::action_t act;
        done = 0;
        while (done < count) begin
            pick   = $urandom_range(0, 99);
            now_us = advance_time(now_us, board.limit);
            if (pick < 5) begin
                offer(ictt_pkg::action_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 31)),
                      48'({$urandom, $urandom}));
                done++;
                continue;
            end
            if (pick < 35)      act = ictt_pkg::ACT_CONNECT;
            else if (pick < 47) act = ictt_pkg::ACT_DISCONNECT;
            else if (pick < 70) act = ictt_pkg::ACT_MESSAGE;
            else                act = ictt_pkg::ACT_TICK;
            slot = $urandom_range(0, 31);
            if (act == ictt_pkg::ACT_CONNECT) begin
                slot = pick_slot(1'b0);
                if (slot < 0) act = ictt_pkg::ACT_MESSAGE;
            end
            if (act == ictt_pkg::ACT_DISCONNECT || act == ictt_pkg::ACT_MESSAGE) begin
                slot = pick_slot(1'b1);
                if (slot < 0) begin
                    act  = ictt_pkg::ACT_CONNECT;
                    slot = pick_slot(1'b0);
                end
            end
            // occasionally land the tick exactly on the head's limit
            if (act == ictt_pkg::ACT_TICK && !board.empty && $urandom_range(0, 6) == 0)
                now_us = board.stamp[board.head] + {8'd0, board.limit};
            offer(act, slot[ID_W-1:0], now_us);
            done++;
        end
    endtask

    initial begin : result_sink
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        bit ready_next;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) board.check_close(m_close_id, m_last_close);
            if (hold_request && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                case (mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = $urandom_range(0, 1);
                    default: ready_next = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_ready <= ready_next;
        end
    end

    initial begin : stimulus
        int order [SLOTS];
        int j;
        int tmp;
        board = new();
        gaps_on    = 1'b1;
        burst_left = 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_action     <= ictt_pkg::ACT_CONNECT;
        s_conn_id    <= '0;
        s_time_now   <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        hold_request <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed pass, limit still at its reset value
        offer(ictt_pkg::ACT_CONNECT, ID_W'(0), 48'd0);
        offer(ictt_pkg::ACT_CONNECT, ID_W'(31), 48'd0);
        offer(ictt_pkg::ACT_CONNECT, ID_W'(0), 48'd5);              // slot already open
        offer(ictt_pkg::ACT_DISCONNECT, ID_W'(5), 48'd5);           // slot never opened
        offer(ictt_pkg::ACT_MESSAGE, ID_W'(7), 48'd5);              // slot never opened
        offer(ictt_pkg::ACT_TICK, ID_W'(0), LIM0);                  // head age equals limit
        offer(ictt_pkg::ACT_CONNECT, ID_W'(5), LIM0);
        offer(ictt_pkg::ACT_MESSAGE, ID_W'(0), LIM0);               // list 31, 5, 0
        offer(ictt_pkg::ACT_TICK, ID_W'(31), 2 * LIM0 + 1);         // three closes
        offer(ictt_pkg::ACT_TICK, ID_W'(0), 2 * LIM0 + 2);          // all marked, nothing new
        offer(ictt_pkg::ACT_MESSAGE, ID_W'(5), 2 * LIM0 + 2);       // refresh keeps the mark
        offer(ictt_pkg::ACT_DISCONNECT, ID_W'(31), 2 * LIM0 + 2);   // head
        offer(ictt_pkg::ACT_CONNECT, ID_W'(31), 2 * LIM0 + 2);      // reopened clean at tail
        offer(ictt_pkg::ACT_TICK, ID_W'(0), 48'hFFFF_FFFF_FFFF);
        offer(ictt_pkg::ACT_TICK, ID_W'(0), 48'd0);                 // time jump on every entry
        offer(ictt_pkg::ACT_TICK, ID_W'(0), LIM0 + 1);
        offer(ictt_pkg::ACT_CONNECT, ID_W'(1), LIM0 + 1);
        offer(ictt_pkg::ACT_MESSAGE, ID_W'(5), LIM0 + 1);           // middle entry to tail
        offer(ictt_pkg::ACT_MESSAGE, ID_W'(5), LIM0 + 2);           // already at tail
        offer(ictt_pkg::ACT_DISCONNECT, ID_W'(1), LIM0 + 2);        // middle
        offer(ictt_pkg::ACT_DISCONNECT, ID_W'(5), LIM0 + 2);        // tail
        offer(ictt_pkg::ACT_TICK, ID_W'(0), 3 * LIM0);
        offer(ictt_pkg::ACT_DISCONNECT, ID_W'(0), 3 * LIM0);
        offer(ictt_pkg::ACT_DISCONNECT, ID_W'(31), 3 * LIM0);
        offer(ictt_pkg::ACT_TICK, ID_W'(0), 4 * LIM0);              // empty list
        now_us = 4 * LIM0;

        drain();
        write_limit('0);
        random_events(35);

        drain();
        write_limit({LIMIT_W{1'b1}});
        random_events(35);

        // back-pressure: full list expires while the result side is held off
        drain();
        write_limit(40'd1000);
        for (int i = 0; i < SLOTS; i++)
            if (board.used[i]) offer(ictt_pkg::ACT_DISCONNECT, i[ID_W-1:0], now_us);
        for (int i = 0; i < SLOTS; i++) order[i] = i;
        for (int i = SLOTS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        gaps_on = 1'b0;
        for (int i = 0; i < SLOTS; i++) offer(ictt_pkg::ACT_CONNECT, order[i][ID_W-1:0], now_us);
        hold_request <= 1'b1;
        now_us = now_us + 48'd1001;
        offer(ictt_pkg::ACT_TICK, ID_W'(0), now_us);
        repeat (10) offer(ictt_pkg::ACT_MESSAGE, ID_W'($urandom_range(0, 31)), now_us);

        drain();
        write_limit(LIMIT_W'($urandom_range(1, 5000)));
        random_events(35);                         // back-to-back transfers
        gaps_on = 1'b1;

        drain();
        write_limit(LIMIT_W'({$urandom, $urandom}));
        random_events(35);

        drain();
        if (board.errors == 0) begin
            $display("idle_connection_timeout_tracker_unit verification clean");
        end else begin
            $display("idle_connection_timeout_tracker_unit verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("idle_connection_timeout_tracker_unit verification failed");
        $finish;
    end

endmodule
